[sv/awu_pkg.sv]
// Shared types, constants and codes for the Adam weight update block.
package awu_pkg;

    localparam int VECTOR_LENGTH_DEF = 1024;
    localparam int INDEX_W           = 10;
    localparam int DEPTH_MAX         = 1 << INDEX_W;
    localparam int CFG_IDX_W         = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DECAY       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_DECAY      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DENOMINATOR_GUARD = 2'd2;

    localparam logic [15:0] FIRST_DECAY_RST       = 16'd58982;
    localparam logic [15:0] SECOND_DECAY_RST      = 16'd64880;
    localparam logic [15:0] DENOMINATOR_GUARD_RST = 16'd43;

    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    typedef struct packed {
        logic [15:0] b1;
        logic [15:0] b2;
        logic [15:0] eps;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLEAR, OP_LOAD,
        OP_S0, OP_S1, OP_S2, OP_S3, OP_S4, OP_S5, OP_S6, OP_S7, OP_S8, OP_S9,
        OP_SQ1, OP_SQ2, OP_ETA, OP_DIV1, OP_DIV2,
        OP_D0, OP_D1, OP_D2, OP_D3, OP_OUT
    } op_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_READ,
        ST_S0, ST_S1, ST_S2, ST_S3, ST_S4, ST_S5, ST_S6, ST_S7, ST_S8, ST_S9,
        ST_SQ1, ST_WSQ1, ST_SQ2, ST_WSQ2, ST_ETA,
        ST_DIV1, ST_WDIV1, ST_DIV2, ST_WDIV2,
        ST_D0, ST_D1, ST_D2, ST_D3, ST_FIN
    } state_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic sq_busy;
        logic div_busy;
    } status_t;

endpackage

[sv/awu_ram.sv]
// Generic single-port RAM with registered read data.
module awu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[sv/awu_sqrt.sv]
// Iterative integer square root, two radicand bits per cycle.
module awu_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        busy,
    output logic [31:0] root
);

    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] rad_reg, rad_next;
    logic [33:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [35:0] rem_try;
    logic [35:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        rem_try   = {rem_reg, rad_reg[63:62]};
        trial     = {2'b00, root_reg, 2'b01};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[61:0], 2'b00};
            cnt_next = cnt_reg + 5'd1;
            if (rem_try >= trial)
            begin
                rem_next  = 34'(rem_try - trial);
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = 34'(rem_try);
                root_next = {root_reg[30:0], 1'b0};
            end
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

[sv/awu_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
module awu_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        busy,
    output logic [63:0] quotient
);

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] num_reg, num_next;
    logic [63:0] den_reg, den_next;
    logic [63:0] rem_reg, rem_next;
    logic [64:0] rem_try;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        rem_try   = {rem_reg, num_reg[63]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 6'd1;
            if (rem_try >= {1'b0, den_reg})
            begin
                rem_next = 64'(rem_try - {1'b0, den_reg});
                num_next = {num_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_try[63:0];
                num_next = {num_reg[62:0], 1'b0};
            end
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign quotient = num_reg;

endmodule

[sv/awu_datapath.sv]
// Datapath: moment stores, shared multiplier, root and divide units, result register.
module awu_datapath
    import awu_pkg::*;
#(
    parameter int VECTOR_LENGTH = VECTOR_LENGTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  cfg_t               cfg,
    input  logic [INDEX_W-1:0] element_index,
    input  logic signed [31:0] weight,
    input  logic signed [31:0] gradient,
    input  logic [19:0]        learning_rate,
    input  logic               last_element,
    output logic [INDEX_W-1:0] result_index,
    output logic signed [31:0] new_weight
);

    localparam int MEM_DEPTH = (VECTOR_LENGTH < DEPTH_MAX) ? VECTOR_LENGTH : DEPTH_MAX;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic [INDEX_W-1:0] idx_reg;
    logic signed [31:0] w_reg;
    logic signed [31:0] g_reg;
    logic [19:0]        eta_reg;
    logic               last_reg;
    logic               inside_reg;
    logic signed [49:0] macc_reg;
    logic signed [31:0] mnew_reg;
    logic [63:0]        g2_reg;
    logic [97:0]        acc_reg;
    logic [63:0]        vnew_reg;
    logic [32:0]        p1_reg;
    logic [32:0]        p2_reg;
    logic [32:0]        pw1_reg, pw1_next;
    logic [32:0]        pw2_reg, pw2_next;
    logic [31:0]        s2_reg;
    logic [31:0]        sv_reg;
    logic [63:0]        etat_reg;
    logic signed [67:0] prod_reg;
    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [INDEX_W-1:0] result_index_reg;
    logic signed [31:0] new_weight_reg;

    logic [31:0]        m_rdata;
    logic [63:0]        v_rdata;
    logic signed [31:0] m_old;
    logic [63:0]        v_old;
    logic [16:0]        c1, c2;
    logic [32:0]        g_neg, m_neg;
    logic [31:0]        gabs, mabs;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod_full;
    logic               mul_en;
    logic [63:0]        prod_u;
    logic signed [33:0] m_shift;
    logic signed [31:0] m_sat;
    logic [63:0]        v_sat;
    logic [32:0]        q1, q2;
    logic [63:0]        den_raw, den;
    logic [63:0]        r_q;
    logic               big;
    logic [40:0]        delta;
    logic signed [42:0] nw_full;
    logic signed [31:0] nw_sat;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic               sq_start, sq_busy;
    logic [63:0]        sq_rad;
    logic [31:0]        sq_root;
    logic               div_start, div_busy;
    logic [63:0]        div_num, div_den;

    assign m_old = inside_reg ? $signed(m_rdata) : 32'sd0;
    assign v_old = inside_reg ? v_rdata : 64'd0;
    assign c1    = 17'(17'h10000 - {1'b0, cfg.b1});
    assign c2    = 17'(17'h10000 - {1'b0, cfg.b2});
    assign g_neg = 33'(-$signed({g_reg[31], g_reg}));
    assign gabs  = g_reg[31] ? g_neg[31:0] : g_reg;
    assign m_neg = 33'(-$signed({mnew_reg[31], mnew_reg}));
    assign mabs  = mnew_reg[31] ? m_neg[31:0] : mnew_reg;
    assign r_q   = div_q_w;

    logic [63:0] div_q_w;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (cmd.op)
            OP_S0:
            begin
                mul_a = {{2{m_old[31]}}, m_old};
                mul_b = {18'd0, cfg.b1};
            end
            OP_S1:
            begin
                mul_a = {17'd0, c1};
                mul_b = {{2{g_reg[31]}}, g_reg};
            end
            OP_S2:
            begin
                mul_a = {2'b00, gabs};
                mul_b = {2'b00, gabs};
            end
            OP_S3:
            begin
                mul_a = {18'd0, cfg.b2};
                mul_b = {2'b00, v_old[63:32]};
            end
            OP_S4:
            begin
                mul_a = {18'd0, cfg.b2};
                mul_b = {2'b00, v_old[31:0]};
            end
            OP_S5:
            begin
                mul_a = {17'd0, c2};
                mul_b = {2'b00, g2_reg[63:32]};
            end
            OP_S6:
            begin
                mul_a = {17'd0, c2};
                mul_b = {2'b00, g2_reg[31:0]};
            end
            OP_S7:
            begin
                mul_a = {1'b0, pw1_reg};
                mul_b = {18'd0, cfg.b1};
            end
            OP_S8:
            begin
                mul_a = {1'b0, pw2_reg};
                mul_b = {18'd0, cfg.b2};
            end
            OP_ETA:
            begin
                mul_a = {14'd0, eta_reg};
                mul_b = {2'b00, s2_reg};
            end
            OP_D0:
            begin
                mul_a = {2'b00, etat_reg[31:0]};
                mul_b = {2'b00, r_q[31:0]};
            end
            OP_D1:
            begin
                mul_a = {2'b00, etat_reg[31:0]};
                mul_b = {2'b00, r_q[63:32]};
            end
            OP_D2:
            begin
                mul_a = {2'b00, etat_reg[63:32]};
                mul_b = {2'b00, r_q[31:0]};
            end
            OP_D3:
            begin
                mul_a = {2'b00, etat_reg[63:32]};
                mul_b = {2'b00, r_q[63:32]};
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;
    assign prod_u    = prod_reg[63:0];

    // First moment: floor shift of the signed sum, clamped to 32 bits.
    assign m_shift = macc_reg[49:16];
    always_comb
    begin
        if (m_shift[33:31] == 3'b000 || m_shift[33:31] == 3'b111)
        begin
            m_sat = m_shift[31:0];
        end
        else if (m_shift[33])
        begin
            m_sat = 32'sh8000_0000;
        end
        else
        begin
            m_sat = 32'sh7FFF_FFFF;
        end
    end

    assign v_sat = (acc_reg[97:80] != '0) ? {64{1'b1}} : acc_reg[79:16];

    assign q1      = (p1_reg == ONE_Q32) ? 33'd1 : 33'(ONE_Q32 - p1_reg);
    assign q2      = 33'(ONE_Q32 - p2_reg);
    assign den_raw = {16'd0, sv_reg, 16'd0} + {48'd0, cfg.eps};
    assign den     = (den_raw == 64'd0) ? 64'd1 : den_raw;

    // Step size: a product at or above 2^64 already exceeds the cap.
    assign big     = (prod_u != 64'd0) || (acc_reg[97:64] != '0);
    assign delta   = big ? 41'h100_0000_0000 : {1'b0, acc_reg[63:24]};
    assign nw_full = mnew_reg[31] ? 43'(43'(w_reg) + $signed({2'b00, delta}))
                                  : 43'(43'(w_reg) - $signed({2'b00, delta}));
    always_comb
    begin
        if (nw_full > 43'sd2147483647)
        begin
            nw_sat = 32'sh7FFF_FFFF;
        end
        else if (nw_full < -43'sd2147483648)
        begin
            nw_sat = 32'sh8000_0000;
        end
        else
        begin
            nw_sat = nw_full[31:0];
        end
    end

    assign sq_start  = (cmd.op == OP_SQ1) || (cmd.op == OP_SQ2);
    assign sq_rad    = (cmd.op == OP_SQ1) ? {q2[31:0], 30'd0} | {31'd0, q2[32], 32'd0} << 30
                                          : vnew_reg;
    assign div_start = (cmd.op == OP_DIV1) || (cmd.op == OP_DIV2);
    assign div_num   = (cmd.op == OP_DIV1) ? {prod_u[54:0], 9'd0} : {mabs, 32'd0};
    assign div_den   = (cmd.op == OP_DIV1) ? {31'd0, q1} : den;

    assign ram_we   = (cmd.op == OP_CLEAR) || ((cmd.op == OP_S9) && inside_reg);
    assign ram_addr = (cmd.op == OP_CLEAR) ? clr_cnt_reg : idx_reg[ADDR_W-1:0];

    awu_ram #(
        .WIDTH (32),
        .DEPTH (MEM_DEPTH)
    ) u_m_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata ((cmd.op == OP_CLEAR) ? 32'd0 : mnew_reg),
        .rdata (m_rdata)
    );

    awu_ram #(
        .WIDTH (64),
        .DEPTH (MEM_DEPTH)
    ) u_v_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata ((cmd.op == OP_CLEAR) ? 64'd0 : vnew_reg),
        .rdata (v_rdata)
    );

    awu_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_rad),
        .busy     (sq_busy),
        .root     (sq_root)
    );

    awu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .quotient (div_q_w)
    );

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        pw1_next     = pw1_reg;
        pw2_next     = pw2_reg;
        if (cmd.op == OP_CLEAR)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
        if ((cmd.op == OP_OUT) && last_reg)
        begin
            pw1_next = p1_reg;
            pw2_next = p2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            pw1_reg     <= ONE_Q32;
            pw2_reg     <= ONE_Q32;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            pw1_reg     <= pw1_next;
            pw2_reg     <= pw2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= prod_full;
        end
        case (cmd.op)
            OP_LOAD:
            begin
                idx_reg    <= element_index;
                w_reg      <= weight;
                g_reg      <= gradient;
                eta_reg    <= learning_rate;
                last_reg   <= last_element;
                inside_reg <= (32'(element_index) < VECTOR_LENGTH);
            end
            OP_S1:  macc_reg <= prod_reg[49:0];
            OP_S2:  macc_reg <= 50'(macc_reg + prod_reg[49:0]);
            OP_S3:
            begin
                g2_reg   <= prod_u;
                mnew_reg <= m_sat;
            end
            OP_S4:  acc_reg <= {2'd0, prod_u, 32'd0};
            OP_S5:  acc_reg <= 98'(acc_reg + {34'd0, prod_u});
            OP_S6:  acc_reg <= 98'(acc_reg + {2'd0, prod_u, 32'd0});
            OP_S7:  acc_reg <= 98'(acc_reg + {34'd0, prod_u});
            OP_S8:
            begin
                vnew_reg <= v_sat;
                p1_reg   <= prod_u[48:16];
            end
            OP_S9:  p2_reg <= prod_u[48:16];
            OP_SQ2: s2_reg <= sq_root;
            OP_ETA: sv_reg <= sq_root;
            OP_DIV2: etat_reg <= div_q_w;
            OP_D1:  acc_reg <= {34'd0, prod_u};
            OP_D2:  acc_reg <= 98'(acc_reg + {2'd0, prod_u, 32'd0});
            OP_D3:  acc_reg <= 98'(acc_reg + {2'd0, prod_u, 32'd0});
            OP_OUT:
            begin
                result_index_reg <= idx_reg;
                new_weight_reg   <= nw_sat;
            end
            default:
            begin
            end
        endcase
    end

    assign status.clr_last = (clr_cnt_reg == ADDR_W'(MEM_DEPTH - 1));
    assign status.sq_busy  = sq_busy;
    assign status.div_busy = div_busy;
    assign result_index    = result_index_reg;
    assign new_weight      = new_weight_reg;

endmodule

[sv/awu_ctrl.sv]
// Controller state machine: clearing pass, step sequencing and handshakes.
module awu_ctrl
    import awu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output cmd_t    cmd,
    input  status_t status
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_S0;
            ST_S0:
            begin
                cmd.op     = OP_S0;
                state_next = ST_S1;
            end
            ST_S1:
            begin
                cmd.op     = OP_S1;
                state_next = ST_S2;
            end
            ST_S2:
            begin
                cmd.op     = OP_S2;
                state_next = ST_S3;
            end
            ST_S3:
            begin
                cmd.op     = OP_S3;
                state_next = ST_S4;
            end
            ST_S4:
            begin
                cmd.op     = OP_S4;
                state_next = ST_S5;
            end
            ST_S5:
            begin
                cmd.op     = OP_S5;
                state_next = ST_S6;
            end
            ST_S6:
            begin
                cmd.op     = OP_S6;
                state_next = ST_S7;
            end
            ST_S7:
            begin
                cmd.op     = OP_S7;
                state_next = ST_S8;
            end
            ST_S8:
            begin
                cmd.op     = OP_S8;
                state_next = ST_S9;
            end
            ST_S9:
            begin
                cmd.op     = OP_S9;
                state_next = ST_SQ1;
            end
            ST_SQ1:
            begin
                cmd.op     = OP_SQ1;
                state_next = ST_WSQ1;
            end
            ST_WSQ1:
            begin
                if (!status.sq_busy)
                begin
                    state_next = ST_SQ2;
                end
            end
            ST_SQ2:
            begin
                cmd.op     = OP_SQ2;
                state_next = ST_WSQ2;
            end
            ST_WSQ2:
            begin
                if (!status.sq_busy)
                begin
                    state_next = ST_ETA;
                end
            end
            ST_ETA:
            begin
                cmd.op     = OP_ETA;
                state_next = ST_DIV1;
            end
            ST_DIV1:
            begin
                cmd.op     = OP_DIV1;
                state_next = ST_WDIV1;
            end
            ST_WDIV1:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                cmd.op     = OP_DIV2;
                state_next = ST_WDIV2;
            end
            ST_WDIV2:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_D0;
                end
            end
            ST_D0:
            begin
                cmd.op     = OP_D0;
                state_next = ST_D1;
            end
            ST_D1:
            begin
                cmd.op     = OP_D1;
                state_next = ST_D2;
            end
            ST_D2:
            begin
                cmd.op     = OP_D2;
                state_next = ST_D3;
            end
            ST_D3:
            begin
                cmd.op     = OP_D3;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.op == OP_OUT)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_READ))
        else $error("accepted word did not start the moment read");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result appeared outside the finish step");

    a_sqrt_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_SQ1 || cmd.op == OP_SQ2) |-> !status.sq_busy)
        else $error("square root started while busy");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_DIV1 || cmd.op == OP_DIV2) |-> !status.div_busy)
        else $error("division started while busy");
`endif

endmodule

[sv/adam_weight_update_top.sv]
// Top level of the fixed-point Adam weight update block.
//
// Usage: the input channel (in_valid/in_ready) takes one word per vector
// element: its index, weight, gradient, learning rate and a flag marking the
// last element of the update step. The output channel (out_valid/out_ready)
// returns one word per input word, in order: the echoed index and the new
// weight, saturated to 32 bits. The configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) writes the two decay factors and the guard
// term; it is always ready and should only be used while the block is idle.
// Each word passes through the single shared divider (two 64-step divisions
// per word) and the shared square root unit (two 32-step roots per word); a
// new word is taken once the previous one has reached the output register.
// After reset the block clears both moment stores, one entry per cycle,
// through every entry of the store (1024 at the default length);
// in_ready stays low during that pass. If the receiver stalls, the finished
// result waits in the output register; the block still accepts and computes
// the next word, then holds it until the output register is free.
module adam_weight_update_top
    import awu_pkg::*;
#(
    parameter int VECTOR_LENGTH = VECTOR_LENGTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [INDEX_W-1:0]   element_index,
    input  logic signed [31:0]   weight,
    input  logic signed [31:0]   gradient,
    input  logic [19:0]          learning_rate,
    input  logic                 last_element,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [INDEX_W-1:0]   result_index,
    output logic signed [31:0]   new_weight
);

    cfg_t    cfg_reg, cfg_next;
    cmd_t    cmd;
    status_t status;

    // Configuration registers; a write to an unused index is dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FIRST_DECAY:       cfg_next.b1  = cfg_data;
                CFG_SECOND_DECAY:      cfg_next.b2  = cfg_data;
                CFG_DENOMINATOR_GUARD: cfg_next.eps = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.b1  <= FIRST_DECAY_RST;
            cfg_reg.b2  <= SECOND_DECAY_RST;
            cfg_reg.eps <= DENOMINATOR_GUARD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;

    // The controller sequences the steps; the datapath holds all arithmetic.
    awu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    awu_datapath #(
        .VECTOR_LENGTH (VECTOR_LENGTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg           (cfg_reg),
        .element_index (element_index),
        .weight        (weight),
        .gradient      (gradient),
        .learning_rate (learning_rate),
        .last_element  (last_element),
        .result_index  (result_index),
        .new_weight    (new_weight)
    );

endmodule

[dv/adam_weight_update_checker.sv]
// Checker for the Adam weight update block: predicts each new weight and compares results.
module adam_weight_update_checker
    import awu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [INDEX_W-1:0]   element_index,
    input  logic signed [31:0]   weight,
    input  logic signed [31:0]   gradient,
    input  logic [19:0]          learning_rate,
    input  logic                 last_element,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [INDEX_W-1:0]   result_index,
    input  logic signed [31:0]   new_weight,
    output int                   mismatches,
    output int                   outstanding,
    output int                   results_seen,
    output int                   steps_seen
);

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic signed [31:0] value;
    } weight_word_t;

    weight_word_t            weight_q[$];
    cfg_t                    cfg_copy;
    logic signed [31:0]      mean_store[DEPTH_MAX];
    logic [63:0]             energy_store[DEPTH_MAX];
    logic [63:0]             b1_power;
    logic [63:0]             b2_power;

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Full update of one element; moment stores and decay powers advance here.
    function automatic logic signed [31:0] adam_new_weight(
        input logic [INDEX_W-1:0] idx, input logic signed [31:0] w,
        input logic signed [31:0] g, input logic [19:0] eta, input logic last);
        longint      mean_acc;
        longint      mean_new;
        longint      nw;
        logic [16:0] c2;
        logic [63:0] gabs, g2, v_old, low, p1, p2, q1, q2, s2, etat, den, mabs, r, delta;
        logic [127:0] v_sum, prod;
        logic [63:0] v_new;
        mean_acc = longint'(cfg_copy.b1) * longint'(mean_store[idx])
                 + longint'(17'd65536 - cfg_copy.b1) * longint'(g);
        mean_new = mean_acc >>> 16;
        if (mean_new > 64'sd2147483647) mean_new = 64'sd2147483647;
        if (mean_new < -64'sd2147483648) mean_new = -64'sd2147483648;

        c2    = 17'd65536 - cfg_copy.b2;
        gabs  = (g < 0) ? 64'(-longint'(g)) : 64'(longint'(g));
        g2    = gabs * gabs;
        v_old = energy_store[idx];
        low   = (64'(cfg_copy.b2) * (v_old & 64'hFFFF) + 64'(c2) * (g2 & 64'hFFFF)) >> 16;
        v_sum = 128'(cfg_copy.b2) * 128'(v_old >> 16) + 128'(c2) * 128'(g2 >> 16) + 128'(low);
        v_new = (v_sum > 128'hFFFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : v_sum[63:0];

        mean_store[idx]   = mean_new[31:0];
        energy_store[idx] = v_new;

        p1 = (b1_power * 64'(cfg_copy.b1)) >> 16;
        p2 = (b2_power * 64'(cfg_copy.b2)) >> 16;
        q1 = 64'(ONE_Q32) - p1;
        q2 = 64'(ONE_Q32) - p2;
        if (q1 == 0) q1 = 1;
        s2   = int_sqrt(q2 << 30);
        etat = ((64'(eta) * s2) << 9) / q1;

        den = (int_sqrt(v_new) << 16) + 64'(cfg_copy.eps);
        if (den == 0) den = 1;
        mabs  = (mean_new < 0) ? 64'(-mean_new) : 64'(mean_new);
        r     = (mabs << 32) / den;
        prod  = (128'(etat) * 128'(r)) >> 24;
        delta = (prod > (128'd1 << 40)) ? (64'd1 << 40) : prod[63:0];

        nw = (mean_new < 0) ? longint'(w) + longint'(delta) : longint'(w) - longint'(delta);
        if (nw > 64'sd2147483647) nw = 64'sd2147483647;
        if (nw < -64'sd2147483648) nw = -64'sd2147483648;

        if (last) begin
            b1_power = p1;
            b2_power = p2;
        end
        return nw[31:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        weight_word_t want;
        if (!rst_n)
        begin
            cfg_copy.b1  = FIRST_DECAY_RST;
            cfg_copy.b2  = SECOND_DECAY_RST;
            cfg_copy.eps = DENOMINATOR_GUARD_RST;
            for (int i = 0; i < DEPTH_MAX; i++)
            begin
                mean_store[i]   = '0;
                energy_store[i] = '0;
            end
            b1_power     = 64'(ONE_Q32);
            b2_power     = 64'(ONE_Q32);
            weight_q.delete();
            mismatches   = 0;
            results_seen = 0;
            steps_seen   = 0;
            outstanding  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FIRST_DECAY:       cfg_copy.b1  = cfg_data;
                    CFG_SECOND_DECAY:      cfg_copy.b2  = cfg_data;
                    CFG_DENOMINATOR_GUARD: cfg_copy.eps = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                want.index = element_index;
                want.value = adam_new_weight(element_index, weight, gradient,
                                             learning_rate, last_element);
                weight_q.push_back(want);
                if (last_element)
                    steps_seen++;
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (weight_q.size() == 0)
                    report("unexpected word, index", result_index, 0);
                else
                begin
                    want = weight_q.pop_front();
                    if (result_index !== want.index)
                        report("result_index", result_index, want.index);
                    if (new_weight !== want.value)
                        report("new_weight", 64'(new_weight), 64'(want.value));
                end
            end
            outstanding = weight_q.size();
        end
    end

endmodule

[dv/adam_weight_update_top_tb.sv]
// Testbench top for the Adam weight update block: stimulus, configuration phases and verdict.
module adam_weight_update_top_tb;
    import awu_pkg::*;

    // Settling wait once every expected word is back; this covers a full drain.
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 2_000_000;
    // Each random phase sends about this many words.
    localparam int PHASE_WORDS  = 270;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [INDEX_W-1:0]   element_index;
    logic signed [31:0]   weight;
    logic signed [31:0]   gradient;
    logic [19:0]          learning_rate;
    logic                 last_element;
    logic                 out_valid;
    logic                 out_ready;
    logic [INDEX_W-1:0]   result_index;
    logic signed [31:0]   new_weight;

    int mismatches;
    int outstanding;
    int results_seen;
    int steps_seen;
    int cycle_count;
    int words_sent;
    int cfg_writes;
    bit long_hold_done;

    adam_weight_update_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .element_index(element_index),
        .weight(weight), .gradient(gradient), .learning_rate(learning_rate),
        .last_element(last_element),
        .out_valid(out_valid), .out_ready(out_ready), .result_index(result_index),
        .new_weight(new_weight)
    );

    adam_weight_update_checker checker_inst (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .element_index(element_index),
        .weight(weight), .gradient(gradient), .learning_rate(learning_rate),
        .last_element(last_element),
        .out_valid(out_valid), .out_ready(out_ready), .result_index(result_index),
        .new_weight(new_weight),
        .mismatches(mismatches), .outstanding(outstanding),
        .results_seen(results_seen), .steps_seen(steps_seen)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[adam_weight_update_top] ERROR");
            $finish;
        end
    end

    // Sender gap for the next word. Every so often the gaps vanish for a
    // stretch so the block sees words back to back.
    function automatic int draw_gap();
        if ((words_sent / 40) % 4 == 3)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    // Offer one word and wait until the block takes it. Valid stays high on
    // exit so a zero gap keeps it high into the next word without a drop.
    task automatic send_word(input logic [INDEX_W-1:0] idx, input logic [31:0] w,
                             input logic [31:0] g, input logic [19:0] eta,
                             input logic last);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        element_index <= idx;
        weight        <= w;
        gradient      <= g;
        learning_rate <= eta;
        last_element  <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Wait until every expected word is back and the block has settled.
    task automatic drain();
        @(posedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic set_decays(input logic [15:0] b1, input logic [15:0] b2,
                              input logic [15:0] eps);
        write_reg(CFG_FIRST_DECAY, b1);
        write_reg(CFG_SECOND_DECAY, b2);
        write_reg(CFG_DENOMINATOR_GUARD, eps);
    endtask

    function automatic logic [31:0] draw_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            2: return 32'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [19:0] draw_rate();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 20'hFFFFF);
            1: return 20'hFFFFF;
            default: return $urandom_range(0, 4096);
        endcase
    endfunction

    // Mostly whole vectors over a short run of consecutive indices, each
    // closed by a last element; the rest are stray words with a random flag.
    task automatic random_phase(input int words);
        int sent;
        int len;
        logic [INDEX_W-1:0] base;
        sent = 0;
        while (sent < words)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                len  = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 8);
                base = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15);
                for (int i = 0; i < len; i++)
                    send_word(base + INDEX_W'(i), draw_value(), draw_value(), draw_rate(),
                              i == len - 1);
                sent += len;
            end
            else
            begin
                send_word($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
                sent++;
            end
        end
    endtask

    // Receiver: a random stall per word, stretches with none, and one long
    // hold-off once traffic is flowing so the block backs up into its input.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!long_hold_done && results_seen >= 150)
            begin
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (3000) @(posedge clk);
            end
            stall = ((results_seen / 50) % 4 == 1) ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cycle_count   = 0;
        words_sent    = 0;
        cfg_writes    = 0;
        long_hold_done = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        element_index = '0;
        weight        = '0;
        gradient      = '0;
        learning_rate = '0;
        last_element  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset settings: field extremes, zero rate,
        // the maximum rate and last flags both ways.
        send_word(10'd0, 32'h0000_0000, 32'h0000_0000, 20'd0, 1'b0);
        send_word(10'd1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'hFFFFF, 1'b0);
        send_word(10'd2, 32'h8000_0000, 32'h8000_0000, 20'hFFFFF, 1'b0);
        send_word(10'd3, 32'h0001_0000, 32'hFFFF_0000, 20'h0_1000, 1'b1);
        send_word(10'd0, 32'hFFFF_FFFF, 32'h0000_0001, 20'h0_0100, 1'b0);
        send_word(10'd1023, 32'h8000_0000, 32'h7FFF_FFFF, 20'hFFFFF, 1'b1);
        send_word(10'd2, 32'h7FFF_FFFF, 32'h8000_0000, 20'hFFFFF, 1'b1);
        send_word(10'd512, 32'h1234_5678, 32'hFFFF_FFFF, 20'h8_0000, 1'b0);
        drain();

        // Zero guard and zero decays: a fresh element with zero gradient gives
        // a zero denominator, and full weight on the gradient makes huge steps
        // that saturate the weight. The unknown register index must be ignored.
        set_decays(16'd0, 16'd0, 16'd0);
        write_reg(CFG_IDX_W'(3), 16'hFFFF);
        send_word(10'd100, 32'h0000_4000, 32'h0000_0000, 20'hFFFFF, 1'b0);
        send_word(10'd101, 32'h7FFF_0000, 32'h0000_0001, 20'hFFFFF, 1'b0);
        send_word(10'd102, 32'h8000_0000, 32'h7FFF_FFFF, 20'hFFFFF, 1'b1);
        send_word(10'd103, 32'h7FFF_FFFF, 32'h8000_0000, 20'hFFFFF, 1'b1);
        send_word(10'd104, 32'h0000_0000, 32'h0000_0100, 20'hFFFFF, 1'b0);
        drain();

        // Upper extremes: decays near one and the largest guard.
        set_decays(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(10'd200, 32'h0000_0000, 32'h7FFF_FFFF, 20'hFFFFF, 1'b1);
        send_word(10'd200, 32'h0000_0000, 32'h8000_0000, 20'hFFFFF, 1'b1);
        send_word(10'd201, 32'h8000_0000, 32'h0000_0001, 20'd1, 1'b0);
        random_phase(PHASE_WORDS / 2);
        drain();

        // Back to the usual values, then random and mixed settings.
        set_decays(FIRST_DECAY_RST, SECOND_DECAY_RST, DENOMINATOR_GUARD_RST);
        random_phase(PHASE_WORDS);
        drain();

        set_decays($urandom, $urandom, $urandom);
        random_phase(PHASE_WORDS);
        drain();

        set_decays(16'd32768, 16'hFFFF, 16'd0);
        random_phase(PHASE_WORDS);
        drain();

        set_decays(16'hFFFF, 16'd0, $urandom);
        write_reg(CFG_IDX_W'(3), $urandom);
        random_phase(PHASE_WORDS / 2);
        drain();

        $display("covered %0d words in %0d update steps, %0d results, %0d register writes",
                 words_sent, steps_seen, results_seen, cfg_writes);
        $display("settings included zero and full-scale decays and guard, plus a long output stall");
        if (mismatches == 0)
            $display("[adam_weight_update_top] OK");
        else
            $display("[adam_weight_update_top] ERROR");
        $finish;
    end

endmodule
